### hdl/lip_pkg.sv
// ----------------------------------------------------------------------------
// lip_pkg
// Shared types and constants of the linear interpolation upsampler.
// ----------------------------------------------------------------------------
package lip_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int FACTOR_W       = 6;
  localparam int FRAC_W         = 16;
  localparam int DEF_MAX_FACTOR = 32;
  localparam int QUEUE_DEPTH    = 2;
  localparam int CFG_ADDR_W     = 2;
  localparam int CFG_DATA_W     = 32;

  // register indexes
  localparam int REG_FACTOR = 0;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last_out;
  } out_item_t;

  // one interval to interpolate, from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [SAMPLE_W-1:0] cur;
    logic                       last;
  } cmd_t;

endpackage

### hdl/lip_front.sv
// ----------------------------------------------------------------------------
// lip_front
// Takes input requests, keeps the previous sample of the vector and turns
// each sample after the first into an interval command for the back end.
// ----------------------------------------------------------------------------
module lip_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lip_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output lip_pkg::cmd_t     cmd_data
);
  import lip_pkg::*;

  logic signed [SAMPLE_W-1:0] prev_r;
  logic                       have_prev_r;
  logic                       in_fire;

  // stall input only when the queue cannot take a command
  assign in_ready = cmd_ready;
  assign in_fire  = in_valid && in_ready;

  // a command only when an earlier sample of this vector exists
  assign cmd_valid     = in_fire && have_prev_r;
  assign cmd_data.prev = prev_r;
  assign cmd_data.cur  = in_data.sample;
  assign cmd_data.last = in_data.last_sample;

  // previous sample tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else if (in_fire) begin
      prev_r      <= in_data.sample;
      have_prev_r <= !in_data.last_sample;
    end
  end

endmodule

### hdl/lip_queue.sv
// ----------------------------------------------------------------------------
// lip_queue
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
module lip_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  lip_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lip_pkg::cmd_t pop_data
);
  import lip_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hdl/lip_back.sv
// ----------------------------------------------------------------------------
// lip_back
// Per interval: serial divide of the scaled difference by the factor, then one
// interpolated point per unstalled cycle by step accumulation, tail if last.
// ----------------------------------------------------------------------------
module lip_back #(
  parameter int MAX_FACTOR = lip_pkg::DEF_MAX_FACTOR
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [lip_pkg::FACTOR_W-1:0]   factor,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  lip_pkg::cmd_t                  cmd_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lip_pkg::out_item_t             out_data
);
  import lip_pkg::*;

  localparam int KW     = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int DIV_W  = SAMPLE_W + FRAC_W;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int ACC_W  = DIV_W + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [1:0] ST_TAIL = 2'd3;

  logic [1:0]                 st_r, st_nxt;
  logic [DCNT_W-1:0]          dcnt_r;
  logic [FACTOR_W-1:0]        rem_r;
  logic [DIV_W-1:0]           quo_r;
  logic                       neg_r;
  logic signed [ACC_W-1:0]    step_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic [KW-1:0]              k_r;
  logic [FACTOR_W-1:0]        f_r;
  logic signed [SAMPLE_W-1:0] cur_r;
  logic                       last_r;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_data_r;

  logic [FACTOR_W-1:0]        f_eff;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W-1:0]        mag;
  logic [FACTOR_W:0]          trial;
  logic                       ge;
  logic [DIV_W-1:0]           quo_nxt;
  logic                       slot_free;
  logic                       emit_pt, emit_tail;
  logic                       k_end;

  // clamp factor to 1..MAX_FACTOR
  always_comb begin
    if (factor == '0) begin
      f_eff = FACTOR_W'(1);
    end else if (factor > FACTOR_W'(MAX_FACTOR)) begin
      f_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      f_eff = factor;
    end
  end

  // interval difference magnitude and sign
  assign diff = {cmd_data.cur[SAMPLE_W-1], cmd_data.cur}
              - {cmd_data.prev[SAMPLE_W-1], cmd_data.prev};
  assign mag  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];

  // restoring divide, one quotient bit per cycle
  assign trial   = {rem_r, quo_r[DIV_W-1]};
  assign ge      = (trial >= {1'b0, f_r});
  assign quo_nxt = {quo_r[DIV_W-2:0], ge};

  assign cmd_ready = (st_r == ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign emit_pt   = (st_r == ST_EMIT) && slot_free;
  assign emit_tail = (st_r == ST_TAIL) && slot_free;
  assign k_end     = (k_r == KW'(f_r - 1'b1));

  // sequencer
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (cmd_valid) st_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (dcnt_r == DCNT_W'(DIV_W - 1)) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_pt && k_end) st_nxt = last_r ? ST_TAIL : ST_IDLE;
      end
      ST_TAIL: begin
        if (emit_tail) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_pt || emit_tail) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          quo_r  <= {mag, {FRAC_W{1'b0}}};
          rem_r  <= '0;
          dcnt_r <= '0;
          neg_r  <= diff[SAMPLE_W];
          acc_r  <= {cmd_data.prev[SAMPLE_W-1], cmd_data.prev, {FRAC_W{1'b0}}};
          cur_r  <= cmd_data.cur;
          last_r <= cmd_data.last;
          f_r    <= f_eff;
          k_r    <= '0;
        end
      end
      ST_DIV: begin
        rem_r  <= ge ? FACTOR_W'(trial - {1'b0, f_r}) : trial[FACTOR_W-1:0];
        quo_r  <= quo_nxt;
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(DIV_W - 1)) begin
          step_r <= neg_r ? -$signed({1'b0, quo_nxt}) : $signed({1'b0, quo_nxt});
        end
      end
      ST_EMIT: begin
        if (emit_pt) begin
          out_data_r.value    <= acc_r[DIV_W-1:FRAC_W];
          out_data_r.last_out <= 1'b0;
          acc_r               <= acc_r + step_r;
          k_r                 <= k_r + 1'b1;
        end
      end
      ST_TAIL: begin
        if (emit_tail) begin
          out_data_r.value    <= cur_r;
          out_data_r.last_out <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // point index never passes the factor
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT) |-> ({{(FACTOR_W+1-KW){1'b0}}, k_r} < {1'b0, f_r}))
    else $error("point index beyond factor");

  // divide always leads into point emission
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV && dcnt_r == DCNT_W'(DIV_W - 1)) |=> (st_r == ST_EMIT))
    else $error("divide did not hand over to emission");

  // tail point carries the last flag and nothing else does
  a_tail_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_pt |=> !out_data_r.last_out) and (emit_tail |=> out_data_r.last_out))
    else $error("last flag on wrong point");

  // a new interval is only taken while the sequencer is idle
  a_idle_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready) |=> (st_r == ST_DIV))
    else $error("interval taken outside idle");

endmodule

### hdl/linear_interp_upsampler.sv
// ----------------------------------------------------------------------------
// linear_interp_upsampler
// Linear interpolation upsampler for signed Q1.15 sample vectors.
//
//   channel  direction  payload                      handshake
//   in_      input      sample, last_sample          in_valid / in_ready
//   out_     output     value, last_out              out_valid / out_ready
//   cfg      APB        factor at byte address 0     psel / penable / pready
//
// A sample after the first of a vector takes a serial divide and then F
// points in the back end (F = clamped factor), plus the tail point when it
// is flagged last; the serial divider sets the floor. The first sample of a
// vector is only held in the front end. A two-entry command queue lets the
// front keep taking samples while the back end works or out_ready is low.
// Reset is synchronous, active low; factor resets to 1.
// ----------------------------------------------------------------------------
module linear_interp_upsampler #(
  parameter int MAX_FACTOR = lip_pkg::DEF_MAX_FACTOR
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lip_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lip_pkg::out_item_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lip_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [lip_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lip_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import lip_pkg::*;

  logic [FACTOR_W-1:0] factor_r;
  logic                fq_valid, fq_ready;
  cmd_t                fq_data;
  logic                qb_valid, qb_ready;
  cmd_t                qb_data;
  logic                reg_hit;

  // configuration register, single word
  assign pready  = 1'b1;
  assign reg_hit = (paddr == CFG_ADDR_W'(REG_FACTOR * 4));
  assign prdata  = {{(CFG_DATA_W-FACTOR_W){1'b0}}, factor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_W'(1);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      factor_r <= pwdata[FACTOR_W-1:0];
    end
  end

  lip_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd_data  (fq_data)
  );

  lip_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  lip_back #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .factor    (factor_r),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd_data  (qb_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the linear interpolation upsampler. A directed
// table covers reset, the sample extremes, one-sample vectors and the factor
// clamps. Random vectors follow, each phase under a new factor. Every accepted
// sample is run through a local interpolator. Each result is compared with
// the oldest predicted point. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lip_pkg::*;

  localparam int     MAX_F        = DEF_MAX_FACTOR;
  localparam int     DRAIN_CYCLES = 100;
  localparam longint CYCLE_LIMIT  = 2_000_000;

  // one row of stimulus: a factor write or a sample, with typed results
  typedef struct {
    bit                is_cfg;
    logic [FACTOR_W-1:0] cfg_val;
    in_item_t          item;
    bit                typed;
    int                n_typed;
    out_item_t         r0;
    out_item_t         r1;
  } stim_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // interpolator state
  logic [FACTOR_W-1:0]        factor_set  = 6'd1;
  logic signed [SAMPLE_W-1:0] held_sample = '0;
  bit                         held_valid  = 1'b0;

  out_item_t  fresh_points[$];
  out_item_t  expected_points[$];
  stim_row_t  dir_tab[$];
  stim_row_t  pending_row;
  bit         quiet_run  = 1'b0;
  int         mismatches = 0;
  longint     cycle_count;

  linear_interp_upsampler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  task automatic flag_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // points prev + k*step of one interval, plus the closing sample on last
  function automatic void interpolate_sample(in_item_t it);
    longint    f;
    longint    step;
    longint    base;
    longint    acc;
    out_item_t pt;
    if (held_valid) begin
      f = longint'(factor_set);
      if (f < 1) f = 1;
      if (f > MAX_F) f = MAX_F;
      step = ((longint'(it.sample) - longint'(held_sample)) * 65536) / f;
      base = longint'(held_sample) * 65536;
      for (longint k = 0; k < f; k++) begin
        acc         = base + k * step;
        pt.value    = SAMPLE_W'(acc >>> FRAC_W);
        pt.last_out = 1'b0;
        fresh_points.push_back(pt);
      end
      if (it.last_sample) begin
        pt.value    = it.sample;
        pt.last_out = 1'b1;
        fresh_points.push_back(pt);
      end
    end
    held_sample = it.sample;
    held_valid  = !it.last_sample;
  endfunction

  // request and result tracking
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        fresh_points.delete();
        interpolate_sample(in_data);
        if (pending_row.typed) begin
          if (pending_row.n_typed > 0) expected_points.push_back(pending_row.r0);
          if (pending_row.n_typed > 1) expected_points.push_back(pending_row.r1);
        end else begin
          foreach (fresh_points[i]) expected_points.push_back(fresh_points[i]);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          flag_mismatch($sformatf("result value=%0d last=%0b with none expected",
                                  out_data.value, out_data.last_out));
        end else begin
          want = expected_points.pop_front();
          if (out_data.value !== want.value)
            flag_mismatch($sformatf("value %0d, expected %0d",
                                    out_data.value, want.value));
          if (out_data.last_out !== want.last_out)
            flag_mismatch($sformatf("last_out %0b, expected %0b",
                                    out_data.last_out, want.last_out));
        end
      end
    end
  end

  // result side backpressure
  initial begin
    int hold;
    int r;
    hold = 0;
    forever begin
      @(posedge clk);
      if (quiet_run) begin
        out_ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1'b1;
          hold = $urandom_range(0, 5);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          hold = $urandom_range(0, 3);
        end else begin
          out_ready <= 1'b0;
          hold = $urandom_range(15, 40);
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (quiet_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_item(stim_row_t row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_data     <= row.item;
    pending_row <= row;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off requests until every predicted point is out, then let the back end settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write of the factor register, then read it back
  task automatic program_factor(logic [FACTOR_W-1:0] val);
    logic [CFG_DATA_W-1:0] word;
    logic [CFG_DATA_W-1:0] rb;
    wait_drained();
    word           = $urandom();
    word[FACTOR_W-1:0] = val;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_ADDR_W'(REG_FACTOR * 4);
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    factor_set = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rb = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rb !== CFG_DATA_W'(val))
      flag_mismatch($sformatf("factor reads back %0h, written %0h", rb, val));
  endtask

  function automatic void add_cfg(logic [FACTOR_W-1:0] val);
    stim_row_t row;
    row.is_cfg  = 1'b1;
    row.cfg_val = val;
    row.item    = '0;
    row.typed   = 1'b0;
    row.n_typed = 0;
    row.r0      = '0;
    row.r1      = '0;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_item(logic signed [SAMPLE_W-1:0] s, logic l);
    stim_row_t row;
    row.is_cfg           = 1'b0;
    row.cfg_val          = '0;
    row.item.sample      = s;
    row.item.last_sample = l;
    row.typed            = 1'b0;
    row.n_typed          = 0;
    row.r0               = '0;
    row.r1               = '0;
    dir_tab.push_back(row);
  endfunction

  function automatic void add_typed(logic signed [SAMPLE_W-1:0] s, logic l, int n,
                                    logic signed [SAMPLE_W-1:0] v0, logic l0,
                                    logic signed [SAMPLE_W-1:0] v1, logic l1);
    stim_row_t row;
    row.is_cfg           = 1'b0;
    row.cfg_val          = '0;
    row.item.sample      = s;
    row.item.last_sample = l;
    row.typed            = 1'b1;
    row.n_typed          = n;
    row.r0               = '{value: v0, last_out: l0};
    row.r1               = '{value: v1, last_out: l1};
    dir_tab.push_back(row);
  endfunction

  // main sequence
  initial begin
    stim_row_t                  row;
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] last_s;
    logic [FACTOR_W-1:0]        f;
    int                         t;
    int                         len;
    int                         count;
    int                         vec;
    int                         r;

    // factor 1 after reset: each interval gives prev, last adds cur
    add_typed(16'sh1000, 1'b0, 0, '0, 1'b0, '0, 1'b0);
    add_typed(16'sh2000, 1'b0, 1, 16'sh1000, 1'b0, '0, 1'b0);
    add_typed(-16'sd32768, 1'b1, 2, 16'sh2000, 1'b0, -16'sd32768, 1'b1);
    // one-sample vector stays silent
    add_typed(16'sd12345, 1'b1, 0, '0, 1'b0, '0, 1'b0);
    // full-scale swing
    add_typed(16'sd32767, 1'b0, 0, '0, 1'b0, '0, 1'b0);
    add_typed(-16'sd32768, 1'b1, 2, 16'sd32767, 1'b0, -16'sd32768, 1'b1);
    // largest factor, rising, flat and falling intervals
    add_cfg(6'd32);
    add_item(-16'sd32768, 1'b0);
    add_item(16'sd32767, 1'b0);
    add_item(16'sd32767, 1'b0);
    add_item(-16'sd32768, 1'b1);
    add_item(16'sd0, 1'b0);
    add_item(-16'sd1, 1'b1);
    // factor zero behaves as one
    add_cfg(6'd0);
    add_typed(16'sd100, 1'b0, 0, '0, 1'b0, '0, 1'b0);
    add_typed(-16'sd100, 1'b1, 2, 16'sd100, 1'b0, -16'sd100, 1'b1);
    // factor above the maximum saturates
    add_cfg(6'd63);
    add_item(-16'sd1, 1'b0);
    add_item(16'sd1, 1'b1);
    // odd factors: step truncation toward zero both ways
    add_cfg(6'd3);
    add_item(16'sd0, 1'b0);
    add_item(16'sd1, 1'b0);
    add_item(-16'sd1, 1'b0);
    add_item(16'sd32767, 1'b1);
    add_cfg(6'd7);
    add_item(16'sd5, 1'b0);
    add_item(-16'sd32768, 1'b0);
    add_item(16'sd2, 1'b1);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) program_factor(dir_tab[i].cfg_val);
      else send_item(dir_tab[i]);
    end

    // random vectors, one factor per phase
    last_s = '0;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       f = 6'd1;
        1:       f = 6'd32;
        2:       f = 6'd0;
        3:       f = 6'd63;
        4:       f = 6'd2;
        default: f = FACTOR_W'($urandom_range(0, 63));
      endcase
      program_factor(f);
      count = 0;
      vec   = 0;
      while (count < 26) begin
        r = $urandom_range(0, 9);
        if (r == 0) len = 1;
        else if (r == 1) len = $urandom_range(12, 24);
        else len = $urandom_range(2, 6);
        quiet_run = ($urandom_range(0, 4) == 0);
        // sender holds until the block has emptied
        if (p == 5 && vec == 2) wait_drained();
        for (int j = 0; j < len; j++) begin
          case ($urandom_range(0, 9))
            0: s = -16'sd32768;
            1: s = 16'sd32767;
            2: begin
              t = int'(last_s) + $urandom_range(0, 80) - 40;
              if (t > 32767) t = 32767;
              if (t < -32768) t = -32768;
              s = SAMPLE_W'(t);
            end
            3: s = $urandom_range(0, 1) ? 16'sd0 : -16'sd1;
            default: s = SAMPLE_W'($urandom());
          endcase
          last_s               = s;
          row.is_cfg           = 1'b0;
          row.cfg_val          = '0;
          row.item.sample      = s;
          row.item.last_sample = (j == len - 1);
          row.typed            = 1'b0;
          row.n_typed          = 0;
          row.r0               = '0;
          row.r1               = '0;
          send_item(row);
          count++;
        end
        vec++;
      end
      quiet_run = 1'b0;
    end

    wait_drained();
    if (expected_points.size() != 0)
      flag_mismatch($sformatf("%0d expected points never came", expected_points.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### linear_interp_upsampler.f
hdl/lip_pkg.sv
hdl/lip_front.sv
hdl/lip_queue.sv
hdl/lip_back.sv
hdl/linear_interp_upsampler.sv
verif/tb.sv
